// ----- hdl/event_log_ring_buffer_defines.svh -----
// assertion macros shared by the event log ring buffer modules
// no dependencies; included by the controller and the datapath
`ifndef EVENT_LOG_RING_BUFFER_DEFINES_SVH
`define EVENT_LOG_RING_BUFFER_DEFINES_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define ELB_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("event log assertion failed");

// expression must never be true out of reset
`define ELB_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("event log assertion failed");

`else

`define ELB_ASSERT(label, clk, rstn, prop)
`define ELB_NEVER(label, clk, rstn, expr)

`endif

`endif

// ----- hdl/elb_pkg.sv -----
// shared types and constants of the event log ring buffer
// no dependencies; used by elb_ctrl, elb_datapath and the top level
package elb_pkg;

    // request kinds carried on the input tuser
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_COUNT = 2'd2;

    // daytime window, start inclusive and end exclusive
    localparam logic [4:0] DAY_START = 5'd6;
    localparam logic [4:0] DAY_END   = 5'd18;

    // field widths
    localparam int TIME_W  = 32;
    localparam int HOUR_W  = 5;
    localparam int SEL_W   = 6;
    localparam int FILL_W  = 6;
    localparam int CMD_W   = 2;

    // longest run of entries one read request returns
    localparam int RESULT_CAP = 32;
    localparam int RUN_W      = 6;

    // packed stream widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 40;

    // commands from the controller to the datapath
    typedef struct packed {
        logic write_event;
        logic start_read;
        logic start_reply;
        logic fetch;
        logic advance;
    } elb_ctrl_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic read_empty;
        logic run_last;
    } elb_stat_t;

endpackage

// ----- hdl/event_log_ring_buffer.sv -----
// top level of the event log ring buffer: stream ports, controller and datapath
// depends on elb_pkg, elb_ctrl and elb_datapath
//
// Usage:
//   Requests enter on the s_axis channel; tuser selects add, read or count.
//   An add stores {time, day flag} at the head of a ring of LOG_DEPTH
//   entries, overwriting the oldest once full, and returns nothing.
//   A read returns up to max_count entries (at most 32) newest first after
//   skipping start_offset entries, one per cycle on m_axis while tready is high, tlast on the last;
//   with nothing to return it gives one result with tuser (entry valid) low.
//   A count request returns one result with the fill level and tuser low.
//   Every result carries the fill level.
// Sequencing:
//   An add is stored on acceptance. A read first sets the read pointer on
//   acceptance, then does the registered memory read in the fetch state,
//   then delivers one entry per cycle while the receiver is ready, as the
//   next read overlaps delivery. A single-result reply goes straight to
//   the send state. A new request is taken once the last result of
//   the previous one has gone; a stalled receiver holds the current result
//   and the block. Reset empties the log; memory contents are not cleared.
module event_log_ring_buffer #(
    parameter int LOG_DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // event_time[31:0], event_hour[36:32], max_count[42:37], start_offset[48:43], zero pad
    input  logic [elb_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  logic [elb_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // entry_time[31:0], entry_day[32], fill_level[38:33], zero pad
    output logic [elb_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // entry_valid[0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    elb_pkg::elb_ctrl_t               ctl;
    elb_pkg::elb_stat_t               stat;
    logic [elb_pkg::TIME_W-1:0]       entry_time;
    logic                             entry_day;
    logic [elb_pkg::FILL_W-1:0]       fill_level;

    // request sequencing
    elb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .command (s_axis_tuser),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // storage and pointers
    elb_datapath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .stat         (stat),
        .event_time   (s_axis_tdata[31:0]),
        .event_hour   (s_axis_tdata[36:32]),
        .max_count    (s_axis_tdata[42:37]),
        .start_offset (s_axis_tdata[48:43]),
        .entry_time   (entry_time),
        .entry_day    (entry_day),
        .entry_valid  (m_axis_tuser),
        .fill_level   (fill_level)
    );

    // result packing
    assign m_axis_tdata = {1'b0, fill_level, entry_day, entry_time};
    assign m_axis_tlast = stat.run_last;

endmodule

// ----- hdl/elb_datapath.sv -----
// datapath of the event log: entry memory, write pointer, fill count,
// read pointer and run counter; depends on elb_pkg and the defines header
`include "event_log_ring_buffer_defines.svh"

module elb_datapath #(
    parameter int LOG_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  elb_pkg::elb_ctrl_t           ctl,
    output elb_pkg::elb_stat_t           stat,
    input  logic [elb_pkg::TIME_W-1:0]   event_time,
    input  logic [elb_pkg::HOUR_W-1:0]   event_hour,
    input  logic [elb_pkg::SEL_W-1:0]    max_count,
    input  logic [elb_pkg::SEL_W-1:0]    start_offset,
    output logic [elb_pkg::TIME_W-1:0]   entry_time,
    output logic                         entry_day,
    output logic                         entry_valid,
    output logic [elb_pkg::FILL_W-1:0]   fill_level
);

    localparam int PTR_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W = (CNT_W > elb_pkg::SEL_W) ? CNT_W : elb_pkg::SEL_W;
    localparam int SUM_W = PTR_W + 2;
    localparam int ENT_W = elb_pkg::TIME_W + 1;

    // entry memory, {day, time}
    logic [ENT_W-1:0] mem [LOG_DEPTH];

    logic [PTR_W-1:0]         wp_reg, wp_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [elb_pkg::RUN_W-1:0] remaining_reg, remaining_next;
    logic                     entry_reg, entry_next;
    logic [ENT_W-1:0]         rd_data_reg;

    logic                     day_flag;
    logic [CMP_W-1:0]         maxc_w, start_w, cnt_w, avail, n_raw, n_cap;
    logic [SUM_W-1:0]         addr_sum;
    logic [PTR_W-1:0]         start_addr, ptr_dec, rd_addr;

    // day flag of a new event
    assign day_flag = (event_time == '0) ||
                      (event_hour >= elb_pkg::DAY_START && event_hour < elb_pkg::DAY_END);

    // run length and emptiness of a read request
    always_comb begin
        maxc_w  = CMP_W'(max_count);
        start_w = CMP_W'(start_offset);
        cnt_w   = CMP_W'(cnt_reg);
        avail   = cnt_w - start_w;
        n_raw   = (avail < maxc_w) ? avail : maxc_w;
        n_cap   = (n_raw > CMP_W'(elb_pkg::RESULT_CAP)) ? CMP_W'(elb_pkg::RESULT_CAP) : n_raw;
    end

    assign stat.read_empty = (max_count == '0) || (start_w >= cnt_w);

    // newest entry after the skip: wp - 1 - start, wrapped once
    always_comb begin
        addr_sum = SUM_W'(wp_reg) + SUM_W'(LOG_DEPTH - 1) - SUM_W'(start_offset);
        if (addr_sum >= SUM_W'(LOG_DEPTH)) begin
            start_addr = PTR_W'(addr_sum - SUM_W'(LOG_DEPTH));
        end else begin
            start_addr = PTR_W'(addr_sum);
        end
    end

    // step toward older entries
    assign ptr_dec = (rd_ptr_reg == '0) ? PTR_W'(LOG_DEPTH - 1) : rd_ptr_reg - 1'b1;
    assign rd_addr = ctl.advance ? ptr_dec : rd_ptr_reg;

    // next-state logic
    always_comb begin
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        remaining_next = remaining_reg;
        entry_next     = entry_reg;
        if (ctl.write_event) begin
            wp_next = (wp_reg == PTR_W'(LOG_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (cnt_reg < CNT_W'(LOG_DEPTH)) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (ctl.start_read) begin
            rd_ptr_next    = start_addr;
            remaining_next = elb_pkg::RUN_W'(n_cap);
            entry_next     = 1'b1;
        end
        if (ctl.start_reply) begin
            entry_next = 1'b0;
        end
        if (ctl.advance) begin
            rd_ptr_next    = ptr_dec;
            remaining_next = remaining_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            cnt_reg       <= '0;
            rd_ptr_reg    <= '0;
            remaining_reg <= '0;
            entry_reg     <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            remaining_reg <= remaining_next;
            entry_reg     <= entry_next;
        end
    end

    // entry memory write and registered read
    always_ff @(posedge aclk) begin
        if (ctl.write_event) begin
            mem[wp_reg] <= {day_flag, event_time};
        end
        if (ctl.fetch || ctl.advance) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result fields; a reply without entry carries zero time and day
    assign entry_time    = entry_reg ? rd_data_reg[elb_pkg::TIME_W-1:0] : '0;
    assign entry_day     = entry_reg & rd_data_reg[ENT_W-1];
    assign entry_valid   = entry_reg;
    assign fill_level    = elb_pkg::FILL_W'(cnt_reg);
    assign stat.run_last = !entry_reg || (remaining_reg == elb_pkg::RUN_W'(1));

    `ELB_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > CNT_W'(LOG_DEPTH))
    `ELB_NEVER(a_wp_range, aclk, aresetn, wp_reg > PTR_W'(LOG_DEPTH - 1))
    `ELB_ASSERT(a_advance_left, aclk, aresetn, ctl.advance |-> remaining_reg > elb_pkg::RUN_W'(1))
    `ELB_ASSERT(a_run_nonzero, aclk, aresetn, ctl.start_read |=> remaining_reg != '0)

endmodule

// ----- hdl/elb_ctrl.sv -----
// controller state machine of the event log: takes requests, sequences
// memory fetches and result delivery; depends on elb_pkg and the defines header
`include "event_log_ring_buffer_defines.svh"

module elb_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [elb_pkg::CMD_W-1:0]   command,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  elb_pkg::elb_stat_t          stat,
    output elb_pkg::elb_ctrl_t          ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SEND  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       s_fire, m_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_SEND);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    // state transitions and datapath commands
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (command)
                        elb_pkg::CMD_ADD: begin
                            ctl.write_event = 1'b1;
                        end
                        elb_pkg::CMD_READ: begin
                            if (stat.read_empty) begin
                                ctl.start_reply = 1'b1;
                                state_next      = ST_SEND;
                            end else begin
                                ctl.start_read = 1'b1;
                                state_next     = ST_FETCH;
                            end
                        end
                        elb_pkg::CMD_COUNT: begin
                            ctl.start_reply = 1'b1;
                            state_next      = ST_SEND;
                        end
                        default: begin
                            // unused request kind is dropped
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                ctl.fetch  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_fire) begin
                    if (stat.run_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ctl.advance = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ELB_NEVER(a_one_side, aclk, aresetn, s_ready && m_valid)
    `ELB_ASSERT(a_read_fetch, aclk, aresetn, ctl.start_read |=> state_reg == ST_FETCH)
    `ELB_ASSERT(a_last_idle, aclk, aresetn, (m_fire && stat.run_last) |=> s_ready)

endmodule

// ----- test/elb_stream_checker.sv -----
`timescale 1ns / 100ps
// stream checker for the event log ring buffer: mirrors the log and checks replies
// depends on elb_pkg; instantiated beside the block by tb_event_log_ring_buffer
module elb_stream_checker #(
    parameter int LOG_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    // event_time[31:0], event_hour[36:32], max_count[42:37], start_offset[48:43], zero pad
    input  logic [elb_pkg::S_DATA_W-1:0] s_axis_tdata,
    // command[1:0]
    input  logic [elb_pkg::CMD_W-1:0]    s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // entry_time[31:0], entry_day[32], fill_level[38:33], zero pad
    input  logic [elb_pkg::M_DATA_W-1:0] m_axis_tdata,
    // entry_valid[0]
    input  logic                         m_axis_tuser,
    input  logic                         m_axis_tlast,
    output int                           error_count,
    output int                           replies_pending
);

    typedef struct packed {
        logic [elb_pkg::TIME_W-1:0] stamp;
        logic                       day;
    } log_entry_t;

    typedef struct packed {
        logic [elb_pkg::TIME_W-1:0] stamp;
        logic                       day;
        logic                       valid;
        logic                       last;
        logic [elb_pkg::FILL_W-1:0] fill;
    } log_reply_t;

    // mirrored log contents and pointers
    log_entry_t log_mirror [LOG_DEPTH];
    int         head_slot;
    int         entry_count;

    // replies still owed by the block, oldest first
    log_reply_t expected_replies [$];
    log_reply_t want;

    initial begin
        error_count = 0;
        replies_pending = 0;
        head_slot = 0;
        entry_count = 0;
    end

    task automatic push_reply(input logic [elb_pkg::TIME_W-1:0] stamp, input logic day,
                              input logic valid, input logic last);
        log_reply_t r;
        r.stamp = stamp;
        r.day   = day;
        r.valid = valid;
        r.last  = last;
        r.fill  = elb_pkg::FILL_W'(entry_count);
        expected_replies.push_back(r);
    endtask

    // update the mirrored log for one request and queue the replies it owes
    task automatic predict_log_request(input logic [elb_pkg::CMD_W-1:0]  cmd,
                                       input logic [elb_pkg::TIME_W-1:0] stamp,
                                       input logic [elb_pkg::HOUR_W-1:0] hour,
                                       input logic [elb_pkg::SEL_W-1:0]  max_req,
                                       input logic [elb_pkg::SEL_W-1:0]  skip);
        int run_len;
        int slot;
        int i;
        case (cmd)
            elb_pkg::CMD_ADD: begin
                log_mirror[head_slot].stamp = stamp;
                // unset time counts as day, else the hour window decides
                log_mirror[head_slot].day =
                    (stamp == '0) ||
                    (hour >= elb_pkg::DAY_START && hour < elb_pkg::DAY_END);
                head_slot = (head_slot + 1) % LOG_DEPTH;
                if (entry_count < LOG_DEPTH) begin
                    entry_count++;
                end
            end
            elb_pkg::CMD_READ: begin
                if (max_req == '0 || int'(skip) >= entry_count) begin
                    // nothing to return: one empty reply
                    push_reply('0, 1'b0, 1'b0, 1'b1);
                end else begin
                    run_len = entry_count - int'(skip);
                    if (int'(max_req) < run_len) begin
                        run_len = int'(max_req);
                    end
                    if (run_len > elb_pkg::RESULT_CAP) begin
                        run_len = elb_pkg::RESULT_CAP;
                    end
                    // newest first, after the skipped ones
                    for (i = 0; i < run_len; i++) begin
                        slot = (head_slot + 2 * LOG_DEPTH - 1 - int'(skip) - i) % LOG_DEPTH;
                        push_reply(log_mirror[slot].stamp, log_mirror[slot].day, 1'b1,
                                   i == run_len - 1);
                    end
                end
            end
            elb_pkg::CMD_COUNT: begin
                push_reply('0, 1'b0, 1'b0, 1'b1);
            end
            default: begin
                // unused command, dropped by the block
            end
        endcase
    endtask

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            head_slot = 0;
            entry_count = 0;
            expected_replies.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_log_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[36:32],
                                    s_axis_tdata[42:37], s_axis_tdata[48:43]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("reply with none pending: entry_time %h", m_axis_tdata[31:0]);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_axis_tdata[31:0] !== want.stamp) begin
                        $error("entry_time: expected %h, got %h", want.stamp,
                               m_axis_tdata[31:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[32] !== want.day) begin
                        $error("entry_day: expected %b, got %b", want.day, m_axis_tdata[32]);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.valid) begin
                        $error("entry_valid: expected %b, got %b", want.valid, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("run_last: expected %b, got %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                    if (m_axis_tdata[38:33] !== want.fill) begin
                        $error("fill_level: expected %0d, got %0d", want.fill,
                               m_axis_tdata[38:33]);
                        error_count++;
                    end
                end
            end
        end
        replies_pending = expected_replies.size();
    end

endmodule

// ----- test/tb_event_log_ring_buffer.sv -----
`timescale 1ns / 100ps
// testbench top for the event log ring buffer: clock, reset, requests, verdict
// depends on elb_pkg, event_log_ring_buffer and elb_stream_checker
module tb_event_log_ring_buffer;

    localparam int LOG_DEPTH = 32;
    localparam logic [elb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 250;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PAD_W = elb_pkg::S_DATA_W - elb_pkg::TIME_W - elb_pkg::HOUR_W
                           - 2 * elb_pkg::SEL_W;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [elb_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
    logic [elb_pkg::CMD_W-1:0]    s_axis_tuser = elb_pkg::CMD_ADD;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [elb_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic                         m_axis_tuser;
    logic                         m_axis_tlast;

    int       error_count;
    int       replies_pending;
    int       burst_left = 1;
    int       idle_cycles = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    event_log_ring_buffer #(
        .LOG_DEPTH(LOG_DEPTH)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    elb_stream_checker #(
        .LOG_DEPTH(LOG_DEPTH)
    ) stream_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .error_count    (error_count),
        .replies_pending(replies_pending)
    );

    always #6 aclk = ~aclk;

    // present one request at the falling edge and hold it until taken
    task automatic send_request(input logic [elb_pkg::CMD_W-1:0]  cmd,
                                input logic [elb_pkg::TIME_W-1:0] stamp,
                                input logic [elb_pkg::HOUR_W-1:0] hour,
                                input logic [elb_pkg::SEL_W-1:0]  max_req,
                                input logic [elb_pkg::SEL_W-1:0]  skip);
        int gap;
        @(negedge aclk);
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{PAD_W{1'b0}}, skip, max_req, hour, stamp};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        // end of burst: drop valid for a random gap, which may be zero
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 7);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // receiver ready pattern: open, choppy and sparse stretches
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_event_log_ring_buffer NOT OK");
            $finish;
        end
    end

    initial begin
        logic [elb_pkg::CMD_W-1:0]  cmd;
        logic [elb_pkg::TIME_W-1:0] stamp;
        logic [elb_pkg::HOUR_W-1:0] hour;
        logic [elb_pkg::SEL_W-1:0]  max_req;
        logic [elb_pkg::SEL_W-1:0]  skip;
        int                         roll;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty log, day window edges, odd hours, read corners
        send_request(elb_pkg::CMD_COUNT, 32'h0, 5'd0, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd5, 6'd0);
        send_request(elb_pkg::CMD_ADD, 32'h0000_0000, 5'd23, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_ADD, 32'hFFFF_FFFF, 5'd5, 6'd63, 6'd63);
        send_request(elb_pkg::CMD_ADD, 32'h0000_0001, 5'd6, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_ADD, 32'h8000_0000, 5'd17, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_ADD, 32'h5555_5555, 5'd18, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_ADD, 32'hAAAA_AAAA, 5'd31, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_ADD, 32'h1234_5678, 5'd24, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_ADD, 32'h0000_0E10, 5'd0, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd0, 6'd0);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd32, 6'd0);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd3, 6'd2);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd4, 6'd8);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd63, 6'd63);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd63, 6'd0);
        send_request(elb_pkg::CMD_COUNT, 32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63);
        send_request(CMD_UNUSED, 32'hDEAD_BEEF, 5'd12, 6'd7, 6'd1);
        send_request(elb_pkg::CMD_READ, 32'h0, 5'd0, 6'd1, 6'd7);

        // random mix, add-heavy so the ring wraps several times
        repeat (RANDOM_REQUESTS) begin
            roll = $urandom_range(0, 19);
            if (roll < 9) begin
                cmd = elb_pkg::CMD_ADD;
            end else if (roll < 16) begin
                cmd = elb_pkg::CMD_READ;
            end else if (roll < 19) begin
                cmd = elb_pkg::CMD_COUNT;
            end else begin
                cmd = CMD_UNUSED;
            end
            stamp = ($urandom_range(0, 9) == 0) ? 32'h0 : 32'($urandom);
            hour = ($urandom_range(0, 7) == 0) ? elb_pkg::HOUR_W'($urandom_range(24, 31))
                                               : elb_pkg::HOUR_W'($urandom_range(0, 23));
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                max_req = '0;
            end else if (roll == 1) begin
                max_req = elb_pkg::SEL_W'($urandom_range(33, 63));
            end else if (roll == 2) begin
                max_req = elb_pkg::SEL_W'(elb_pkg::RESULT_CAP);
            end else begin
                max_req = elb_pkg::SEL_W'($urandom_range(1, 12));
            end
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                skip = elb_pkg::SEL_W'($urandom_range(0, 4));
            end else if (roll < 9) begin
                skip = elb_pkg::SEL_W'($urandom_range(0, 31));
            end else begin
                skip = elb_pkg::SEL_W'($urandom_range(32, 63));
            end
            send_request(cmd, stamp, hour, max_req, skip);
        end

        // drain outstanding replies, then let the block settle
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait (replies_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && replies_pending == 0) begin
            $display("tb_event_log_ring_buffer OK");
        end else begin
            $display("tb_event_log_ring_buffer NOT OK");
        end
        $finish;
    end

endmodule
